/* rtl/panel_init_sequence_interpreter_defines.svh */
// ----------------------------------------------------------------------------
// panel init sequence interpreter: assertion macros
// shared property wrappers for the concurrent checks in the rtl
// ----------------------------------------------------------------------------
`ifndef PANEL_INIT_SEQUENCE_INTERPRETER_DEFINES_SVH
`define PANEL_INIT_SEQUENCE_INTERPRETER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PISI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PISI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pisi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisi_pkg
// types, codes and action expansion shared by the script interpreter
// ----------------------------------------------------------------------------
package pisi_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_COUNT,
        PH_DATA,
        PH_DELAY,
        PH_DRAIN
    } phase_t;

    // action codes on the output stream
    typedef enum logic [2:0] {
        ACT_CMD   = 3'd0,
        ACT_DATA  = 3'd1,
        ACT_WAIT  = 3'd2,
        ACT_DELAY = 3'd3,
        ACT_HWRST = 3'd4,
        ACT_DONE  = 3'd5,
        ACT_ERROR = 3'd6
    } action_t;

    // kind of work record handed from parser to expander
    typedef enum logic [3:0] {
        K_NONE,
        K_CMD,
        K_DATA,
        K_WAIT,
        K_DELAY,
        K_HWRST,
        K_END,
        K_SWRST,
        K_WINDOW,
        K_CURSOR
    } kind_t;

    // what follows the base actions of a record
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_DONE,
        TAIL_ERROR
    } tail_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        tail_t      tail;
    } op_t;

    typedef struct packed {
        logic [11:0] panel_width;
        logic [15:0] panel_height;
        logic        busy_pol;
    } cfg_t;

    typedef struct packed {
        action_t    code;
        logic [7:0] value;
    } act_t;

    // configuration register indexes
    localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BUSY_POL     = 2'd2;

    localparam logic [11:0] WIDTH_RESET  = 12'd200;
    localparam logic [15:0] HEIGHT_RESET = 16'd200;

    // sentinel bytes
    localparam logic [7:0] SENT_BASE   = 8'hF0;
    localparam logic [7:0] SENT_END    = 8'hF0;
    localparam logic [7:0] SENT_WAIT   = 8'hF1;
    localparam logic [7:0] SENT_DELAY  = 8'hF2;
    localparam logic [7:0] SENT_HWRST  = 8'hF3;
    localparam logic [7:0] SENT_SWRST  = 8'hF4;
    localparam logic [7:0] SENT_WINDOW = 8'hF5;
    localparam logic [7:0] SENT_CURSOR = 8'hF6;

    // panel commands used by the expansions
    localparam logic [7:0] CMD_SW_RESET = 8'h12;
    localparam logic [7:0] CMD_WIN_X    = 8'h44;
    localparam logic [7:0] CMD_WIN_Y    = 8'h45;
    localparam logic [7:0] CMD_CUR_X    = 8'h4E;
    localparam logic [7:0] CMD_CUR_Y    = 8'h4F;

    // number of actions a record kind expands to, tail excluded
    function automatic logic [3:0] base_count(input kind_t kind);
        logic [3:0] n;
        unique case (kind)
            K_NONE:   n = 4'd0;
            K_SWRST:  n = 4'd2;
            K_WINDOW: n = 4'd8;
            K_CURSOR: n = 4'd5;
            default:  n = 4'd1;
        endcase
        return n;
    endfunction

    // action number idx of a record
    function automatic act_t action_at(input op_t op, input logic [3:0] idx,
                                       input cfg_t cfg);
        act_t        r;
        logic [11:0] wm1;
        logic [15:0] hm1;
        wm1 = cfg.panel_width - 12'd1;
        hm1 = cfg.panel_height - 16'd1;
        r.code  = ACT_DATA;
        r.value = 8'd0;
        if (idx == base_count(op.kind)) begin
            r.code = (op.tail == TAIL_DONE) ? ACT_DONE : ACT_ERROR;
        end
        else begin
            unique case (op.kind)
                K_CMD:
                begin
                    r.code  = ACT_CMD;
                    r.value = op.value;
                end
                K_DATA:
                begin
                    r.value = op.value;
                end
                K_WAIT:
                begin
                    r.code  = ACT_WAIT;
                    r.value = {7'd0, cfg.busy_pol};
                end
                K_DELAY:
                begin
                    r.code  = ACT_DELAY;
                    r.value = op.value;
                end
                K_HWRST:  r.code = ACT_HWRST;
                K_END:    r.code = ACT_DONE;
                K_SWRST:
                begin
                    if (idx == 4'd0) begin
                        r.code  = ACT_CMD;
                        r.value = CMD_SW_RESET;
                    end
                    else begin
                        r.code  = ACT_WAIT;
                        r.value = {7'd0, cfg.busy_pol};
                    end
                end
                K_WINDOW:
                begin
                    case (idx)
                        4'd0:
                        begin
                            r.code  = ACT_CMD;
                            r.value = CMD_WIN_X;
                        end
                        4'd2:    r.value = wm1[10:3];
                        4'd3:
                        begin
                            r.code  = ACT_CMD;
                            r.value = CMD_WIN_Y;
                        end
                        4'd6:    r.value = hm1[7:0];
                        4'd7:    r.value = hm1[15:8];
                        default: r.value = 8'd0;
                    endcase
                end
                K_CURSOR:
                begin
                    if (idx == 4'd0) begin
                        r.code  = ACT_CMD;
                        r.value = CMD_CUR_X;
                    end
                    else if (idx == 4'd2) begin
                        r.code  = ACT_CMD;
                        r.value = CMD_CUR_Y;
                    end
                end
                default: r.code = ACT_ERROR;
            endcase
        end
        return r;
    endfunction

endpackage

/* rtl/panel_init_sequence_interpreter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_init_sequence_interpreter
// turns a panel init script byte stream into executor actions
//
//   channel  | dir | tdata            | tuser      | tlast
//   ---------+-----+------------------+------------+-----------------
//   s_*      | in  | [7:0] script_byte| -          | script_last
//   m_*      | out | [7:0] action_val | [2:0] act  | run_last
//   cfg_*    | in  | write only: cfg_we, cfg_index, cfg_data
//
// one script byte is accepted per cycle while the record queue has room
// each byte leaves 0 to 9 actions; the expander emits one action per cycle
// while m_tready allows, so plain bytes pass at one per cycle; window/cursor
// bytes give 8/5 actions, one more if a byte also ends the script in done or error
// ready right after reset, no clearing pass; config registers reset to 200/200/0
// m_tready low backs up the queue and s_tready drops when FIFO_DEPTH records wait
// ----------------------------------------------------------------------------
module panel_init_sequence_interpreter #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] script_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] action_value
    output logic [2:0]  m_tuser,    // [2:0] action
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [11:0]        width_reg;
    logic [15:0]        height_reg;
    logic               busy_pol_reg;
    pisi_pkg::cfg_t     cfg;
    logic               take;
    logic               push;
    pisi_pkg::op_t      push_op;
    logic               full;
    logic               pop;
    logic               head_valid;
    pisi_pkg::op_t      head_op;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg    <= pisi_pkg::WIDTH_RESET;
            height_reg   <= pisi_pkg::HEIGHT_RESET;
            busy_pol_reg <= 1'b0;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                pisi_pkg::REG_PANEL_WIDTH:  width_reg    <= cfg_data[11:0];
                pisi_pkg::REG_PANEL_HEIGHT: height_reg   <= cfg_data;
                pisi_pkg::REG_BUSY_POL:     busy_pol_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    assign cfg.panel_width  = width_reg;
    assign cfg.panel_height = height_reg;
    assign cfg.busy_pol     = busy_pol_reg;

    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;

    pisi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .script_byte (s_tdata),
        .script_last (s_tlast),
        .push        (push),
        .push_op     (push_op)
    );

    pisi_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    pisi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

/* rtl/pisi_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisi_front
// script byte parser: tracks the phase and emits at most one work record per byte
// ----------------------------------------------------------------------------
module pisi_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      script_byte,
    input  logic            script_last,
    output logic            push,
    output pisi_pkg::op_t   push_op
);

    pisi_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       data_left_reg, data_left_next;
    logic [7:0]       left_dec;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg     <= pisi_pkg::PH_OPCODE;
            data_left_reg <= 8'd0;
        end
        else if (take) begin
            phase_reg     <= phase_next;
            data_left_reg <= data_left_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        data_left_next = data_left_reg;
        push_op.kind   = pisi_pkg::K_NONE;
        push_op.value  = script_byte;
        push_op.tail   = pisi_pkg::TAIL_NONE;
        left_dec       = data_left_reg - 8'd1;

        unique case (phase_reg)
            pisi_pkg::PH_DRAIN:
            begin
                if (script_last) begin
                    phase_next = pisi_pkg::PH_OPCODE;
                end
            end
            pisi_pkg::PH_COUNT:
            begin
                push_op.kind  = pisi_pkg::K_CMD;
                push_op.value = data_left_reg;
                if (script_byte == 8'd0 || script_last) begin
                    phase_next     = pisi_pkg::PH_OPCODE;
                    data_left_next = 8'd0;
                    if (script_byte == 8'd0) begin
                        push_op.tail = script_last ? pisi_pkg::TAIL_DONE
                                                   : pisi_pkg::TAIL_NONE;
                    end
                    else begin
                        push_op.tail = pisi_pkg::TAIL_ERROR;
                    end
                end
                else begin
                    data_left_next = script_byte;
                    phase_next     = pisi_pkg::PH_DATA;
                end
            end
            pisi_pkg::PH_DATA:
            begin
                push_op.kind   = pisi_pkg::K_DATA;
                data_left_next = left_dec;
                if (left_dec == 8'd0) begin
                    phase_next   = pisi_pkg::PH_OPCODE;
                    push_op.tail = script_last ? pisi_pkg::TAIL_DONE
                                               : pisi_pkg::TAIL_NONE;
                end
                else if (script_last) begin
                    phase_next     = pisi_pkg::PH_OPCODE;
                    data_left_next = 8'd0;
                    push_op.tail   = pisi_pkg::TAIL_ERROR;
                end
            end
            pisi_pkg::PH_DELAY:
            begin
                push_op.kind   = pisi_pkg::K_DELAY;
                phase_next     = pisi_pkg::PH_OPCODE;
                data_left_next = 8'd0;
                push_op.tail   = script_last ? pisi_pkg::TAIL_DONE
                                             : pisi_pkg::TAIL_NONE;
            end
            pisi_pkg::PH_OPCODE:
            begin
                data_left_next = 8'd0;
                if (script_byte < pisi_pkg::SENT_BASE) begin
                    if (script_last) begin
                        push_op.tail = pisi_pkg::TAIL_ERROR;
                    end
                    else begin
                        data_left_next = script_byte;
                        phase_next     = pisi_pkg::PH_COUNT;
                    end
                end
                else if (script_byte == pisi_pkg::SENT_END) begin
                    push_op.kind = pisi_pkg::K_END;
                    phase_next   = script_last ? pisi_pkg::PH_OPCODE : pisi_pkg::PH_DRAIN;
                end
                else if (script_byte == pisi_pkg::SENT_DELAY) begin
                    if (script_last) begin
                        push_op.tail = pisi_pkg::TAIL_ERROR;
                    end
                    else begin
                        phase_next = pisi_pkg::PH_DELAY;
                    end
                end
                else begin
                    case (script_byte)
                        pisi_pkg::SENT_WAIT:   push_op.kind = pisi_pkg::K_WAIT;
                        pisi_pkg::SENT_HWRST:  push_op.kind = pisi_pkg::K_HWRST;
                        pisi_pkg::SENT_SWRST:  push_op.kind = pisi_pkg::K_SWRST;
                        pisi_pkg::SENT_WINDOW: push_op.kind = pisi_pkg::K_WINDOW;
                        pisi_pkg::SENT_CURSOR: push_op.kind = pisi_pkg::K_CURSOR;
                        default:               push_op.kind = pisi_pkg::K_NONE;
                    endcase
                    // unknown sentinels only matter when they close the script
                    push_op.tail = script_last ? pisi_pkg::TAIL_DONE
                                               : pisi_pkg::TAIL_NONE;
                end
            end
            default:
            begin
                phase_next     = pisi_pkg::PH_OPCODE;
                data_left_next = 8'd0;
            end
        endcase

        push = take && (push_op.kind != pisi_pkg::K_NONE ||
                        push_op.tail != pisi_pkg::TAIL_NONE);
    end

endmodule

/* rtl/pisi_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisi_fifo
// short register queue of work records between parser and expander
// ----------------------------------------------------------------------------
module pisi_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pisi_pkg::op_t   push_op,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output pisi_pkg::op_t   head_op
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pisi_pkg::op_t  mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = mem_reg[rd_ptr_reg];

endmodule

/* rtl/pisi_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisi_back
// action expander: walks each work record one action per cycle, while m_tready
// does not stall it, into the registered output stage
// ----------------------------------------------------------------------------
`include "panel_init_sequence_interpreter_defines.svh"

module pisi_back (
    input  logic            clk,
    input  logic            rst_n,
    input  pisi_pkg::cfg_t  cfg,
    input  logic            head_valid,
    input  pisi_pkg::op_t   head_op,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic [2:0]      m_tuser,
    output logic            m_tlast
);

    logic [3:0]          idx_reg, idx_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [7:0]          m_tdata_reg;
    logic [2:0]          m_tuser_reg;
    logic                m_tlast_reg;
    logic [3:0]          total;
    logic                is_last;
    logic                load;
    pisi_pkg::act_t      act;

    always_comb begin
        total   = pisi_pkg::base_count(head_op.kind)
                + {3'd0, head_op.tail != pisi_pkg::TAIL_NONE};
        is_last = ((idx_reg + 4'd1) == total);
        act     = pisi_pkg::action_at(head_op, idx_reg, cfg);
        // output stage takes a new action when empty or being drained
        load    = head_valid && (!m_tvalid_reg || m_tready);
        pop     = load && is_last;

        idx_next = idx_reg;
        if (load) begin
            idx_next = is_last ? 4'd0 : idx_reg + 4'd1;
        end

        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idx_reg      <= 4'd0;
            m_tvalid_reg <= 1'b0;
        end
        else begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            m_tdata_reg <= act.value;
            m_tuser_reg <= act.code;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `PISI_ASSERT_NOW(a_pop_has_head, clk, rst_n, pop, head_valid, "pop from empty queue")
    `PISI_ASSERT_NOW(a_idx_in_range, clk, rst_n, head_valid, idx_reg < total, "action index past record end")
    `PISI_ASSERT_NEXT(a_last_on_pop, clk, rst_n, load, m_tlast == $past(pop), "tlast does not match record end")
    `PISI_ASSERT_NOW(a_idle_idx_zero, clk, rst_n, !head_valid, idx_reg == 4'd0, "index left mid-record with empty queue")

endmodule
